>>> rtl/tcpq_pkg.sv
package tcpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_CLASSES     = 3;
    localparam int CLS_W           = 2;
    localparam int ID_W            = 16;
    localparam int STATUS_W        = 2;
    localparam int TDATA_W         = 24;   // class + id, padded to bytes

    // request kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_SERVE = 1'b1;

    // class codes
    localparam logic [CLS_W-1:0] CLS_DOWNLOAD = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MUSIC    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_GAME     = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 2'd0,
        ST_DROPPED = 2'd1,
        ST_SERVED  = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the incoming request
        logic load_direct;  // commit add / empty serve, load result
        logic serve;        // pop selected queue, start slot read
        logic load_served;  // load served id into the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_add;
        logic any_ready;    // at least one queue holds an id
        logic out_free;     // result register can take a new result
    } dp_sts_t;

endpackage

>>> rtl/three_class_priority_queue.sv
// Flow: an add request, or a serve with all queues empty, is committed in the execute
//   state and its result loaded; a serve takes an extra state for the registered slot-memory read.
// Each result load waits while a pending result is not taken; the controller handles
//   one request at a time.
// Reset: synchronous, active low; all queues empty, no result pending. The slot
//   memory is not cleared; only slots holding queued ids are ever read.
module three_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [1:0] task_class, [17:2] task_id, rest zero
    input  logic               s_tuser,   // [0] kind (0 add, 1 serve)
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [1:0] served_class, [17:2] served_id, rest zero
    output logic [STATUS_W-1:0] m_tuser   // [1:0] status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    logic [CLS_W-1:0] m_cls;
    logic [ID_W-1:0]  m_id;

    // sequencer: idle -> execute -> (read for serves) -> idle
    tcpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // queue pointers, fill counts, slot memory and result register
    tcpq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_kind   (s_tuser),
        .s_cls    (s_tdata[CLS_W-1:0]),
        .s_id     (s_tdata[CLS_W+ID_W-1:CLS_W]),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_status (m_tuser),
        .m_cls    (m_cls),
        .m_id     (m_id)
    );

    // pack result fields, zero padding on top
    assign m_tdata = {(TDATA_W - CLS_W - ID_W)'(0), m_id, m_cls};

`ifndef SYNTHESIS
    // a request is handled alone: ready drops right after acceptance
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while one is in flight");

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.load_direct, cmd.serve, cmd.load_served}))
        else $error("conflicting datapath commands");

    // a result is only loaded when the result register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_direct || cmd.load_served) |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // no direct result is loaded in the cycle after a serve command
    a_serve_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.serve |=> !cmd.load_direct)
        else $error("direct result loaded during a pending slot read");
`endif

endmodule

>>> rtl/tcpq_ctrl.sv
module tcpq_ctrl
    import tcpq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.is_add || !sts.any_ready) begin
                    if (sts.out_free) begin
                        cmd.load_direct = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.serve  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (sts.out_free) begin
                    cmd.load_served = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tcpq_dpath.sv
module tcpq_dpath
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic                s_kind,
    input  logic [CLS_W-1:0]    s_cls,
    input  logic [ID_W-1:0]     s_id,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [STATUS_W-1:0] m_status,
    output logic [CLS_W-1:0]    m_cls,
    output logic [ID_W-1:0]     m_id
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = PTR_W + 1;
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    function automatic logic [ADDR_W-1:0] class_base(input logic [CLS_W-1:0] c);
        logic [ADDR_W-1:0] b;
        case (c)
            CLS_MUSIC: b = ADDR_W'(QUEUE_DEPTH);
            CLS_GAME:  b = ADDR_W'(2 * QUEUE_DEPTH);
            default:   b = '0;
        endcase
        return b;
    endfunction

    // captured request
    logic             kind_reg;
    logic [CLS_W-1:0] cls_reg;
    logic [ID_W-1:0]  id_reg;

    logic [PTR_W-1:0] head_reg [NUM_CLASSES];
    logic [PTR_W-1:0] head_next[NUM_CLASSES];
    logic [CNT_W-1:0] fill_reg [NUM_CLASSES];
    logic [CNT_W-1:0] fill_next[NUM_CLASSES];

    logic [ID_W-1:0]  slot_mem [MEM_DEPTH];
    logic [ID_W-1:0]  rdata_reg;
    logic [CLS_W-1:0] srv_cls_reg;

    logic                ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0] ostatus_reg;
    logic [CLS_W-1:0]    ocls_reg;
    logic [ID_W-1:0]     oid_reg;

    logic [PTR_W-1:0]  cls_head;
    logic [CNT_W-1:0]  cls_fill;
    logic              add_ok;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [CLS_W-1:0]  srv_sel;
    logic [PTR_W-1:0]  srv_head;
    logic [PTR_W-1:0]  head_inc;
    logic              any_ready;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              mem_we;
    logic              out_free;

    // add side: tail slot of the request's class
    always_comb begin
        cls_head = '0;
        cls_fill = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (cls_reg == CLS_W'(c)) begin
                cls_head = head_reg[c];
                cls_fill = fill_reg[c];
            end
        end
        add_ok   = (cls_reg < CLS_W'(NUM_CLASSES)) && (cls_fill != CNT_W'(QUEUE_DEPTH));
        tail_sum = SUM_W'(cls_head) + SUM_W'(cls_fill);
        tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
        wr_addr  = class_base(cls_reg) + ADDR_W'(tail);
    end

    // serve side: strict priority, class 0 first
    always_comb begin
        any_ready = (fill_reg[0] != '0) || (fill_reg[1] != '0) || (fill_reg[2] != '0);
        if (fill_reg[0] != '0) begin
            srv_sel = CLS_DOWNLOAD;
        end else if (fill_reg[1] != '0) begin
            srv_sel = CLS_MUSIC;
        end else begin
            srv_sel = CLS_GAME;
        end
        srv_head = head_reg[srv_sel];
        head_inc = (srv_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : srv_head + 1'b1;
        rd_addr  = class_base(srv_sel) + ADDR_W'(srv_head);
    end

    assign mem_we   = cmd.load_direct && (kind_reg == KIND_ADD) && add_ok;
    assign out_free = !ovalid_reg || m_ready;

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            head_next[c] = head_reg[c];
            fill_next[c] = fill_reg[c];
            if (mem_we && cls_reg == CLS_W'(c)) begin
                fill_next[c] = fill_reg[c] + 1'b1;
            end
            if (cmd.serve && srv_sel == CLS_W'(c)) begin
                fill_next[c] = fill_reg[c] - 1'b1;
                head_next[c] = head_inc;
            end
        end
    end

    always_comb begin
        if (cmd.load_direct || cmd.load_served) begin
            ovalid_next = 1'b1;
        end else if (m_ready) begin
            ovalid_next = 1'b0;
        end else begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end else begin
            ovalid_reg <= ovalid_next;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= head_next[c];
                fill_reg[c] <= fill_next[c];
            end
        end
    end

    // slot memory: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[wr_addr] <= id_reg;
        end
        if (cmd.serve) begin
            rdata_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            cls_reg  <= s_cls;
            id_reg   <= s_id;
        end
        if (cmd.serve) begin
            srv_cls_reg <= srv_sel;
        end
        if (cmd.load_direct) begin
            if (kind_reg == KIND_ADD) begin
                ostatus_reg <= add_ok ? ST_ADDED : ST_DROPPED;
            end else begin
                ostatus_reg <= ST_EMPTY;
            end
            ocls_reg <= '0;
            oid_reg  <= '0;
        end else if (cmd.load_served) begin
            ostatus_reg <= ST_SERVED;
            ocls_reg    <= srv_cls_reg;
            oid_reg     <= rdata_reg;
        end
    end

    assign sts.is_add    = (kind_reg == KIND_ADD);
    assign sts.any_ready = any_ready;
    assign sts.out_free  = out_free;

    assign m_valid  = ovalid_reg;
    assign m_status = ostatus_reg;
    assign m_cls    = ocls_reg;
    assign m_id     = oid_reg;

endmodule
